// File: rtl/zps_pkg.sv
// Shared types, constants and helper functions for the zone proof-of-work statistics block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package zps_pkg;

  // Widths of the value, words, nonce, zero count, thresholds, counters and config fields.
  localparam int ValW   = 256;
  localparam int WordW  = 64;
  localparam int NonceW = 32;
  localparam int ZeroW  = 9;
  localparam int ThrW   = 9;
  localparam int NumThr = 4;
  localparam int CntW   = 33;
  localparam int CmpW   = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgValW = 32;

  // Reset values of the configuration registers.
  localparam logic [CmpW-1:0] TargetReset = 32'h1d00ffff;
  localparam logic [NumThr-1:0][ThrW-1:0] ThrReset = {9'd56, 9'd48, 9'd40, 9'd32};

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgTargetCompact = 3'd0,
    CfgThreshold0    = 3'd1,
    CfgThreshold1    = 3'd2,
    CfgThreshold2    = 3'd3,
    CfgThreshold3    = 3'd4
  } cfg_idx_e;

  // One input beat.
  typedef struct packed {
    logic [WordW-1:0]  digest_bytes_0_7;
    logic [WordW-1:0]  digest_bytes_8_15;
    logic [WordW-1:0]  digest_bytes_16_23;
    logic [WordW-1:0]  digest_bytes_24_31;
    logic [NonceW-1:0] nonce;
    logic              last_in_zone;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [WordW-1:0]  min_value_top;
    logic [WordW-1:0]  min_value_upper_mid;
    logic [WordW-1:0]  min_value_lower_mid;
    logic [WordW-1:0]  min_value_bottom;
    logic [NonceW-1:0] min_value_nonce;
    logic [CntW-1:0]   zone_item_count;
    logic [CntW-1:0]   tail_count_0;
    logic [CntW-1:0]   tail_count_1;
    logic [CntW-1:0]   tail_count_2;
    logic [CntW-1:0]   tail_count_3;
    logic [CntW-1:0]   network_hit_count;
  } res_beat_t;

  // Settings that the classification stage needs.
  typedef struct packed {
    logic [NumThr-1:0][ThrW-1:0] thr;
    logic [ValW-1:0]             target;
  } cfg_t;

  // A classified digest on its way to the accumulators.
  typedef struct packed {
    logic [ValW-1:0]   value;
    logic [NonceW-1:0] nonce;
    logic              last_in_zone;
    logic [NumThr-1:0] tail_hit;
    logic              net_hit;
  } cls_t;

  // Saturating increment of a statistics counter.
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    return (&c) ? c : c + CntW'(1);
  endfunction

  // Leading zero count of a 256-bit value by binary halving; all zeros gives 256.
  function automatic logic [ZeroW-1:0] clz256(input logic [ValW-1:0] v);
    logic [ValW-1:0]  x;
    logic [ZeroW-1:0] n;
    x = v;
    n = '0;
    for (int s = 7; s >= 0; s--) begin
      if ((x >> (ValW - (1 << s))) == '0) begin
        n = n | ZeroW'(1 << s);
        x = x << (1 << s);
      end
    end
    if (!x[ValW-1]) begin
      n = n + ZeroW'(1);
    end
    return n;
  endfunction

  // Expands the compact target: exponent byte, sign bit and 23-bit mantissa.
  // A negative or overflowing target decodes to zero.
  function automatic logic [ValW-1:0] decode_target(input logic [CmpW-1:0] c);
    logic [7:0]      e;
    logic [22:0]     m;
    logic            neg;
    logic            ovf;
    logic [7:0]      sh;
    logic [ValW-1:0] t;
    e   = c[31:24];
    m   = c[22:0];
    neg = (m != '0) && c[23];
    ovf = (m != '0) && ((e > 8'd34) || ((m > 23'hff) && (e > 8'd33)) ||
                        ((m > 23'hffff) && (e > 8'd32)));
    t   = '0;
    sh  = '0;
    if (!neg && !ovf) begin
      // Small exponents drop whole mantissa bytes from the bottom.
      if (e <= 8'd3) begin
        m  = m >> {2'd3 - e[1:0], 3'b000};
        sh = '0;
      end else begin
        sh = e - 8'd3;
      end
      if (sh < 8'd32) begin
        t = {{(ValW - 23){1'b0}}, m} << {sh[4:0], 3'b000};
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/zps_if.sv
// Valid/ready channel interfaces for input beats, result beats and register writes.
// Depends on zps_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface zps_in_if;
  logic                valid;
  logic                ready;
  zps_pkg::in_beat_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface zps_res_if;
  logic                valid;
  logic                ready;
  zps_pkg::res_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface zps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [zps_pkg::CfgIdxW-1:0]   index;
  logic [zps_pkg::CfgValW-1:0]   value;
  modport source (output valid, output index, output value, input ready);
  modport sink   (input valid, input index, input value, output ready);
endinterface

`default_nettype wire

// File: rtl/zps_cfg.sv
// Configuration registers with a registered expansion of the compact target.
// Depends on zps_pkg and zps_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module zps_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  zps_cfg_if.sink        cfg_i,
  output zps_pkg::cfg_t  cfg_o
);

  logic [zps_pkg::CmpW-1:0]                        target_compact_q;
  logic [zps_pkg::NumThr-1:0][zps_pkg::ThrW-1:0]   thr_q;
  logic [zps_pkg::ValW-1:0]                        target_q;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Register file; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_compact_q <= zps_pkg::TargetReset;
      thr_q            <= zps_pkg::ThrReset;
    end else if (cfg_i.valid) begin
      unique case (zps_pkg::cfg_idx_e'(cfg_i.index))
        zps_pkg::CfgTargetCompact: target_compact_q <= cfg_i.value;
        zps_pkg::CfgThreshold0:    thr_q[0] <= cfg_i.value[zps_pkg::ThrW-1:0];
        zps_pkg::CfgThreshold1:    thr_q[1] <= cfg_i.value[zps_pkg::ThrW-1:0];
        zps_pkg::CfgThreshold2:    thr_q[2] <= cfg_i.value[zps_pkg::ThrW-1:0];
        zps_pkg::CfgThreshold3:    thr_q[3] <= cfg_i.value[zps_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // The expanded target follows the compact register in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= zps_pkg::decode_target(zps_pkg::TargetReset);
    end else begin
      target_q <= zps_pkg::decode_target(target_compact_q);
    end
  end

  assign cfg_o.thr    = thr_q;
  assign cfg_o.target = target_q;

endmodule

`default_nettype wire

// File: rtl/zps_classify.sv
// Input register and classification stage: leading zeros, threshold hits, target compare.
// Depends on zps_pkg and zps_in_if.
`timescale 1ns / 1ps
`default_nettype none

module zps_classify (
  input  logic           clk_i,
  input  logic           rst_ni,
  zps_in_if.sink         in_i,
  input  zps_pkg::cfg_t  cfg_i,
  output logic           cls_valid_o,
  output zps_pkg::cls_t  cls_o,
  input  logic           cls_ready_i
);

  logic                       in_vld_q;
  zps_pkg::in_beat_t          in_q;
  logic                       cls_vld_q;
  zps_pkg::cls_t              cls_q;
  zps_pkg::cls_t              cls_d;
  logic                       cls_open;
  logic                       in_open;
  logic [zps_pkg::ValW-1:0]   value;
  logic [zps_pkg::ZeroW-1:0]  zeros;

  // Each stage opens when it is empty or its beat moves on.
  assign cls_open   = !cls_vld_q || cls_ready_i;
  assign in_open    = !in_vld_q || cls_open;
  assign in_i.ready = in_open;

  // Byte 31 is the most significant byte of the value.
  assign value = {in_q.digest_bytes_24_31, in_q.digest_bytes_16_23,
                  in_q.digest_bytes_8_15, in_q.digest_bytes_0_7};
  assign zeros = zps_pkg::clz256(value);

  // Classification of the registered beat.
  always_comb begin
    cls_d.value        = value;
    cls_d.nonce        = in_q.nonce;
    cls_d.last_in_zone = in_q.last_in_zone;
    for (int i = 0; i < zps_pkg::NumThr; i++) begin
      cls_d.tail_hit[i] = (zeros >= cfg_i.thr[i]);
    end
    cls_d.net_hit = (value <= cfg_i.target);
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      cls_vld_q <= 1'b0;
    end else begin
      if (in_open) begin
        in_vld_q <= in_i.valid;
      end
      if (cls_open) begin
        cls_vld_q <= in_vld_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (in_open && in_i.valid) begin
      in_q <= in_i.data;
    end
    if (cls_open && in_vld_q) begin
      cls_q <= cls_d;
    end
  end

  assign cls_valid_o = cls_vld_q;
  assign cls_o       = cls_q;

endmodule

`default_nettype wire

// File: rtl/zps_accum.sv
// Zone accumulators (minimum, counters) and the result register.
// Depends on zps_pkg and zps_res_if.
`timescale 1ns / 1ps
`default_nettype none

module zps_accum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cls_valid_i,
  input  zps_pkg::cls_t  cls_i,
  output logic           cls_ready_o,
  zps_res_if.source      res_o
);

  logic [zps_pkg::ValW-1:0]                       min_val_q, min_val_d;
  logic [zps_pkg::NonceW-1:0]                     min_nonce_q, min_nonce_d;
  logic [zps_pkg::CntW-1:0]                       item_q, item_d;
  logic [zps_pkg::NumThr-1:0][zps_pkg::CntW-1:0]  tail_q, tail_d;
  logic [zps_pkg::CntW-1:0]                       net_q, net_d;
  logic                                           res_vld_q;
  zps_pkg::res_beat_t                             res_q, res_d;
  logic                                           out_free;
  logic                                           take;
  logic                                           upd;

  // A beat that closes a zone waits for room in the result register.
  assign out_free    = !res_vld_q || res_o.ready;
  assign cls_ready_o = !cls_i.last_in_zone || out_free;
  assign take        = cls_valid_i && cls_ready_o;

  // Smaller value wins; an equal value wins only with a lower nonce.
  assign upd = (cls_i.value < min_val_q) ||
               ((cls_i.value == min_val_q) && (cls_i.nonce < min_nonce_q));

  // Next statistics with this beat counted in.
  always_comb begin
    min_val_d   = upd ? cls_i.value : min_val_q;
    min_nonce_d = upd ? cls_i.nonce : min_nonce_q;
    item_d      = zps_pkg::sat_inc(item_q);
    for (int i = 0; i < zps_pkg::NumThr; i++) begin
      tail_d[i] = cls_i.tail_hit[i] ? zps_pkg::sat_inc(tail_q[i]) : tail_q[i];
    end
    net_d = cls_i.net_hit ? zps_pkg::sat_inc(net_q) : net_q;

    res_d.min_value_top       = min_val_d[255:192];
    res_d.min_value_upper_mid = min_val_d[191:128];
    res_d.min_value_lower_mid = min_val_d[127:64];
    res_d.min_value_bottom    = min_val_d[63:0];
    res_d.min_value_nonce     = min_nonce_d;
    res_d.zone_item_count     = item_d;
    res_d.tail_count_0        = tail_d[0];
    res_d.tail_count_1        = tail_d[1];
    res_d.tail_count_2        = tail_d[2];
    res_d.tail_count_3        = tail_d[3];
    res_d.network_hit_count   = net_d;
  end

  // Zone store: updated per beat, cleared when the zone closes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_val_q   <= '1;
      min_nonce_q <= '1;
      item_q      <= '0;
      tail_q      <= '0;
      net_q       <= '0;
    end else if (take) begin
      if (cls_i.last_in_zone) begin
        min_val_q   <= '1;
        min_nonce_q <= '1;
        item_q      <= '0;
        tail_q      <= '0;
        net_q       <= '0;
      end else begin
        min_val_q   <= min_val_d;
        min_nonce_q <= min_nonce_d;
        item_q      <= item_d;
        tail_q      <= tail_d;
        net_q       <= net_d;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (take && cls_i.last_in_zone) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (take && cls_i.last_in_zone) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

endmodule

`default_nettype wire

// File: rtl/zone_pow_statistics_core.sv
// Top level of the zone proof-of-work statistics block.
// Depends on zps_pkg, zps_if, zps_cfg, zps_classify and zps_accum.
//
//   Channel  Direction  Beat contents
//   in_i     sink       four digest words, nonce, last-of-zone mark
//   res_o    source     minimum value and nonce, item, tail and network-hit counts
//   cfg_i    sink       register index and write data
//
// One digest is accepted every cycle unless a closing beat stalls. Each beat passes the
// input, classify and result registers; a zone result is registered from its closing beat.
// Reset clears the zone store and loads the register defaults; the expanded
// target is registered from the compact target register after a target write.
// Only a beat that closes a zone waits on the result side: it stalls while
// an earlier result is still held, and the stall backs up through the stages.
`timescale 1ns / 1ps
`default_nettype none

module zone_pow_statistics_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  zps_in_if.sink      in_i,
  zps_res_if.source   res_o,
  zps_cfg_if.sink     cfg_i
);

  zps_pkg::cfg_t  cfg;
  logic           cls_valid;
  zps_pkg::cls_t  cls;
  logic           cls_ready;

  zps_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  zps_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg),
    .cls_valid_o (cls_valid),
    .cls_o       (cls),
    .cls_ready_i (cls_ready)
  );

  zps_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (cls_valid),
    .cls_i       (cls),
    .cls_ready_o (cls_ready),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// File: rtl/zps_checker.sv
// Port-level checks on result beats of the statistics block, bound to the top level.
// Depends on zps_pkg and zone_pow_statistics_core.
`timescale 1ns / 1ps
`default_nettype none

module zps_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                res_valid_i,
  input logic                res_ready_i,
  input zps_pkg::res_beat_t  res_data_i
);

  // A held result keeps its contents until it is taken.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result beat changed while stalled");

  // A zone always holds at least its closing digest.
  a_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_data_i.zone_item_count != '0)
    else $error("result beat with empty zone");

  // No tail count exceeds the zone's item count.
  a_tails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_data_i.tail_count_0 <= res_data_i.zone_item_count) &&
                    (res_data_i.tail_count_1 <= res_data_i.zone_item_count) &&
                    (res_data_i.tail_count_2 <= res_data_i.zone_item_count) &&
                    (res_data_i.tail_count_3 <= res_data_i.zone_item_count))
    else $error("tail count above item count");

  // Network hits are a subset of the zone's digests.
  a_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_data_i.network_hit_count <= res_data_i.zone_item_count)
    else $error("network hit count above item count");

endmodule

bind zone_pow_statistics_core zps_checker u_zps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for zone_pow_statistics_core: digest, result and register channels.
// Depends on zps_pkg and the channel interfaces in zps_if; results are checked against
// a behavioral predictor of the per-zone statistics kept inside this file.
`timescale 1ns / 1ps

module testbench;

  // Widths taken from the package.
  localparam int ValW    = zps_pkg::ValW;
  localparam int WordW   = zps_pkg::WordW;
  localparam int NonceW  = zps_pkg::NonceW;
  localparam int ThrW    = zps_pkg::ThrW;
  localparam int NumThr  = zps_pkg::NumThr;
  localparam int CntW    = zps_pkg::CntW;
  localparam int CmpW    = zps_pkg::CmpW;
  localparam int CfgIdxW = zps_pkg::CfgIdxW;
  localparam int CfgValW = zps_pkg::CfgValW;

  localparam int TimeoutNs      = 10_000_000;
  localparam int SettleCycles   = 8;
  localparam int LongHoldCycles = 300;
  localparam int NumPhases      = 8;
  localparam int ItemsPerPhase  = 210;
  localparam int HoldPhase      = 2;
  localparam int MaxPrinted     = 40;

  // Index that no register decodes; writes to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 3'd7;

  localparam logic [ValW-1:0] AllOnes       = '1;
  localparam logic [ValW-1:0] DefaultTarget = {64'h0000_0000_ffff_0000, 192'd0};
  localparam logic [ValW-1:0] FortyZeros    = {64'h0000_0000_00ff_ffff, {192{1'b1}}};

  // One line of the directed plan: either a register write or a digest beat.
  typedef struct packed {
    bit                  reg_write;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgValW-1:0]  reg_val;
    zps_pkg::in_beat_t   beat;
    bit                  typed;
    zps_pkg::res_beat_t  stats;
  } plan_row_t;

  // What the sender knows about each offered beat.
  typedef struct packed {
    bit                  typed;
    zps_pkg::res_beat_t  stats;
  } beat_note_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  zps_in_if  in_if ();
  zps_res_if res_if ();
  zps_cfg_if cfg_if ();

  zone_pow_statistics_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Predictor copy of the registers and of the zone store.
  logic [CmpW-1:0]   target_cfg;
  logic [ThrW-1:0]   zero_thr [NumThr];
  logic [ValW-1:0]   zone_min;
  logic [NonceW-1:0] zone_min_nonce;
  logic [CntW-1:0]   zone_items;
  logic [CntW-1:0]   zone_tails [NumThr];
  logic [CntW-1:0]   zone_net;

  zps_pkg::res_beat_t  zone_stats_q [$];
  beat_note_t          beat_note_q [$];

  logic [ValW-1:0] prev_digest = '0;
  bit send_burst   = 1'b0;
  bit take_burst   = 1'b0;
  bit res_hold_req = 1'b0;

  int mismatches    = 0;
  int digests_seen  = 0;
  int results_seen  = 0;
  int reg_writes    = 0;
  int long_holds    = 0;
  int in_stall_cyc  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(TimeoutNs);
    $display("testbench: FAIL");
    $finish;
  end

  // Prints one mismatch line (up to a cap) and counts it.
  task automatic report_mismatch(input string msg);
    if (mismatches < MaxPrinted) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [WordW-1:0] got,
                             input logic [WordW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  function automatic logic [CntW-1:0] sat_bump(input logic [CntW-1:0] c);
    return (&c) ? c : c + CntW'(1);
  endfunction

  function automatic int unsigned lead_zeros(input logic [ValW-1:0] v);
    int unsigned n;
    n = 0;
    for (int i = ValW - 1; i >= 0; i--) begin
      if (v[i]) break;
      n++;
    end
    return n;
  endfunction

  // Expands nBits into the full target; a negative or oversized target is zero.
  function automatic logic [ValW-1:0] expand_compact(input logic [CmpW-1:0] c);
    logic [7:0]  ex;
    logic [22:0] mant;
    ex   = c[31:24];
    mant = c[22:0];
    if (mant == '0 || c[23]) return '0;
    if (ex > 34 || (mant > 23'hff && ex > 33) || (mant > 23'hffff && ex > 32)) return '0;
    if (ex <= 3) return ValW'(mant >> (8 * (3 - ex)));
    return ValW'(mant) << (8 * (ex - 3));
  endfunction

  function automatic zps_pkg::res_beat_t zone_stats(input logic [ValW-1:0] mv,
                                                    input logic [NonceW-1:0] mn,
                                                    input logic [CntW-1:0] cnt, t0, t1, t2, t3,
                                                    net);
    zps_pkg::res_beat_t r;
    r.min_value_top       = mv[255:192];
    r.min_value_upper_mid = mv[191:128];
    r.min_value_lower_mid = mv[127:64];
    r.min_value_bottom    = mv[63:0];
    r.min_value_nonce     = mn;
    r.zone_item_count     = cnt;
    r.tail_count_0        = t0;
    r.tail_count_1        = t1;
    r.tail_count_2        = t2;
    r.tail_count_3        = t3;
    r.network_hit_count   = net;
    return r;
  endfunction

  function automatic zps_pkg::in_beat_t pack_digest(input logic [ValW-1:0] v,
                                                    input logic [NonceW-1:0] n,
                                                    input logic last);
    zps_pkg::in_beat_t b;
    b.digest_bytes_24_31 = v[255:192];
    b.digest_bytes_16_23 = v[191:128];
    b.digest_bytes_8_15  = v[127:64];
    b.digest_bytes_0_7   = v[63:0];
    b.nonce              = n;
    b.last_in_zone       = last;
    return b;
  endfunction

  function automatic plan_row_t beat_row(input logic [ValW-1:0] v, input logic [NonceW-1:0] n,
                                         input logic last, input bit typed,
                                         input zps_pkg::res_beat_t st);
    plan_row_t r;
    r       = '0;
    r.beat  = pack_digest(v, n, last);
    r.typed = typed;
    r.stats = st;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgValW-1:0] val);
    plan_row_t r;
    r           = '0;
    r.reg_write = 1'b1;
    r.reg_idx   = idx;
    r.reg_val   = val;
    return r;
  endfunction

  function automatic logic [ValW-1:0] rand_value();
    return {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Digest mix: plain random, shifted down for many leading zeros, near the target, repeats, all ones or all zeros.
  function automatic logic [ValW-1:0] draw_digest(input logic [ValW-1:0] tgt);
    case ($urandom_range(0, 9))
      0:       return rand_value();
      1, 2, 3: return rand_value() >> $urandom_range(0, 256);
      4:       return tgt + ValW'($urandom_range(0, 2)) - ValW'(1);
      5:       return prev_digest;
      6:       return $urandom_range(0, 1) ? AllOnes : '0;
      7:       return rand_value() >> $urandom_range(24, 70);
      default: return rand_value() >> $urandom_range(0, 64);
    endcase
  endfunction

  task automatic clear_zone();
    zone_min       = '1;
    zone_min_nonce = '1;
    zone_items     = '0;
    zone_net       = '0;
    for (int i = 0; i < NumThr; i++) zone_tails[i] = '0;
  endtask

  // Folds one digest into the zone store; a closing beat yields the zone statistics.
  task automatic tally_digest(input zps_pkg::in_beat_t b, output bit closes,
                              output zps_pkg::res_beat_t st);
    logic [ValW-1:0] v;
    int unsigned     zeros;
    v = {b.digest_bytes_24_31, b.digest_bytes_16_23, b.digest_bytes_8_15, b.digest_bytes_0_7};
    zeros = lead_zeros(v);
    zone_items = sat_bump(zone_items);
    for (int i = 0; i < NumThr; i++) begin
      if (zeros >= 32'(zero_thr[i])) zone_tails[i] = sat_bump(zone_tails[i]);
    end
    if (v <= expand_compact(target_cfg)) zone_net = sat_bump(zone_net);
    if (v < zone_min || (v == zone_min && b.nonce < zone_min_nonce)) begin
      zone_min       = v;
      zone_min_nonce = b.nonce;
    end
    closes = b.last_in_zone;
    st = zone_stats(zone_min, zone_min_nonce, zone_items, zone_tails[0], zone_tails[1],
                    zone_tails[2], zone_tails[3], zone_net);
    if (closes) clear_zone();
  endtask

  // Scoreboard: checks result beats, tracks register writes and predicts accepted digests.
  always @(posedge clk_i) begin
    beat_note_t          note;
    zps_pkg::res_beat_t  want;
    zps_pkg::res_beat_t  pred;
    bit                  closes;
    if (!rst_ni) begin
      target_cfg = zps_pkg::TargetReset;
      for (int i = 0; i < NumThr; i++) zero_thr[i] = zps_pkg::ThrReset[i];
      clear_zone();
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (zone_stats_q.size() == 0) begin
          report_mismatch("result beat while no zone was closed");
        end else begin
          want = zone_stats_q.pop_front();
          check_field("min_value_top", res_if.data.min_value_top, want.min_value_top);
          check_field("min_value_upper_mid", res_if.data.min_value_upper_mid,
                      want.min_value_upper_mid);
          check_field("min_value_lower_mid", res_if.data.min_value_lower_mid,
                      want.min_value_lower_mid);
          check_field("min_value_bottom", res_if.data.min_value_bottom, want.min_value_bottom);
          check_field("min_value_nonce", WordW'(res_if.data.min_value_nonce),
                      WordW'(want.min_value_nonce));
          check_field("zone_item_count", WordW'(res_if.data.zone_item_count),
                      WordW'(want.zone_item_count));
          check_field("tail_count_0", WordW'(res_if.data.tail_count_0),
                      WordW'(want.tail_count_0));
          check_field("tail_count_1", WordW'(res_if.data.tail_count_1),
                      WordW'(want.tail_count_1));
          check_field("tail_count_2", WordW'(res_if.data.tail_count_2),
                      WordW'(want.tail_count_2));
          check_field("tail_count_3", WordW'(res_if.data.tail_count_3),
                      WordW'(want.tail_count_3));
          check_field("network_hit_count", WordW'(res_if.data.network_hit_count),
                      WordW'(want.network_hit_count));
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          zps_pkg::CfgTargetCompact: target_cfg  = cfg_if.value;
          zps_pkg::CfgThreshold0:    zero_thr[0] = cfg_if.value[ThrW-1:0];
          zps_pkg::CfgThreshold1:    zero_thr[1] = cfg_if.value[ThrW-1:0];
          zps_pkg::CfgThreshold2:    zero_thr[2] = cfg_if.value[ThrW-1:0];
          zps_pkg::CfgThreshold3:    zero_thr[3] = cfg_if.value[ThrW-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        note = beat_note_q.pop_front();
        tally_digest(in_if.data, closes, pred);
        digests_seen++;
        if (closes) zone_stats_q.insert(zone_stats_q.size(), note.typed ? note.stats : pred);
      end
      if (in_if.valid && !in_if.ready) in_stall_cyc++;
    end
  end

  // Result side: random stall before each beat, one long hold when asked.
  initial begin
    int unsigned wait_n;
    res_if.ready = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (res_hold_req) begin
        wait_n       = LongHoldCycles;
        res_hold_req = 1'b0;
        long_holds++;
      end else begin
        wait_n = take_burst ? 0 : $urandom_range(0, 16);
      end
      if (wait_n != 0) begin
        res_if.ready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // Offers one digest beat after a random gap and returns once it is accepted.
  task automatic offer_beat(input zps_pkg::in_beat_t b, input bit typed,
                            input zps_pkg::res_beat_t st);
    int unsigned gap;
    beat_note_t  note;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    note.typed = typed;
    note.stats = st;
    beat_note_q.insert(beat_note_q.size(), note);
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Leaves valid high so that back-to-back writes need no gap; the caller lowers it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgValW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.value <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    reg_writes++;
  endtask

  // Waits until every closed zone has reported and the pipeline has emptied.
  // The first edge lets the scoreboard record a closing beat taken at the last edge.
  task automatic settle_pipeline();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (zone_stats_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    plan_row_t          plan [$];
    logic [CfgValW-1:0] tgt_word;
    logic [CfgValW-1:0] thr_word [NumThr];
    logic [ThrW-1:0]    thr_val;
    logic [ValW-1:0]    v;
    logic [NonceW-1:0]  n;
    logic               last;
    int unsigned        zone_left;
    int unsigned        zone_len_max;

    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = zps_pkg::CfgTargetCompact;
    cfg_if.value = '0;
    zone_left    = 0;

    // Directed plan. Reset registers first: target 0x1d00ffff, thresholds 32/40/48/56.
    plan.insert(plan.size(), beat_row(AllOnes, '1, 1'b1, 1'b1,
                                      zone_stats(AllOnes, '1, 1, 0, 0, 0, 0, 0)));
    plan.insert(plan.size(), beat_row('0, '0, 1'b1, 1'b1,
                                      zone_stats('0, '0, 1, 1, 1, 1, 1, 1)));
    // Equal values: the lower nonce wins whichever comes first.
    plan.insert(plan.size(), beat_row(FortyZeros, 32'd5, 1'b0, 1'b0, '0));
    plan.insert(plan.size(), beat_row(FortyZeros, 32'd3, 1'b1, 1'b1,
                                      zone_stats(FortyZeros, 32'd3, 2, 2, 2, 0, 0, 2)));
    plan.insert(plan.size(), beat_row(DefaultTarget, 32'd3, 1'b0, 1'b0, '0));
    plan.insert(plan.size(), beat_row(DefaultTarget, 32'd9, 1'b1, 1'b1,
                                      zone_stats(DefaultTarget, 32'd3, 2, 2, 0, 0, 0, 2)));
    plan.insert(plan.size(), beat_row(DefaultTarget + ValW'(1), 32'h1234_5678, 1'b1, 1'b1,
                                      zone_stats(DefaultTarget + ValW'(1), 32'h1234_5678,
                                                 1, 1, 0, 0, 0, 0)));
    // Threshold zero, exactly 256, above 256 and all nine bits set (upper bits ignored).
    plan.insert(plan.size(), reg_row(zps_pkg::CfgThreshold0, 32'd0));
    plan.insert(plan.size(), reg_row(zps_pkg::CfgThreshold1, 32'd256));
    plan.insert(plan.size(), reg_row(zps_pkg::CfgThreshold2, 32'd257));
    plan.insert(plan.size(), reg_row(zps_pkg::CfgThreshold3, 32'hffff_ffff));
    // Small exponent: the mantissa loses its low byte, target becomes 0x1234.
    plan.insert(plan.size(), reg_row(zps_pkg::CfgTargetCompact, 32'h0212_3456));
    plan.insert(plan.size(), beat_row(ValW'(16'h1234), 32'd7, 1'b1, 1'b1,
                                      zone_stats(ValW'(16'h1234), 32'd7, 1, 1, 0, 0, 0, 1)));
    plan.insert(plan.size(), beat_row('0, 32'd1, 1'b1, 1'b1,
                                      zone_stats('0, 32'd1, 1, 1, 1, 0, 0, 1)));
    plan.insert(plan.size(), beat_row(ValW'(16'h1235), 32'd2, 1'b1, 1'b1,
                                      zone_stats(ValW'(16'h1235), 32'd2, 1, 1, 0, 0, 0, 0)));
    // Negative target decodes to zero; a write to an unused index changes nothing.
    plan.insert(plan.size(), reg_row(CfgUnusedIdx, 32'hffff_ffff));
    plan.insert(plan.size(), reg_row(zps_pkg::CfgTargetCompact, 32'h0492_3456));
    plan.insert(plan.size(), reg_row(zps_pkg::CfgThreshold1, 32'd1));
    plan.insert(plan.size(), beat_row('0, '1, 1'b1, 1'b1,
                                      zone_stats('0, '1, 1, 1, 1, 0, 0, 1)));
    plan.insert(plan.size(), beat_row(ValW'(1), '0, 1'b1, 1'b1,
                                      zone_stats(ValW'(1), '0, 1, 1, 1, 0, 0, 0)));
    // Overflowing target, then the largest exponent that still fits.
    plan.insert(plan.size(), reg_row(zps_pkg::CfgTargetCompact, 32'h2200_ffff));
    plan.insert(plan.size(), beat_row('0, 32'd4, 1'b0, 1'b0, '0));
    plan.insert(plan.size(), beat_row(ValW'(1), 32'd4, 1'b1, 1'b0, '0));
    plan.insert(plan.size(), reg_row(zps_pkg::CfgTargetCompact, 32'h2200_0001));
    plan.insert(plan.size(), beat_row({8'h01, 248'd0}, 32'd10, 1'b0, 1'b0, '0));
    plan.insert(plan.size(), beat_row({8'h01, 248'd1}, 32'd11, 1'b0, 1'b0, '0));
    plan.insert(plan.size(), beat_row(AllOnes, 32'd12, 1'b1, 1'b0, '0));
    // Sign bit with a zero mantissa is still a zero target, not a negative one.
    plan.insert(plan.size(), reg_row(zps_pkg::CfgTargetCompact, 32'h0380_0000));
    plan.insert(plan.size(), beat_row('0, 32'h8000_0000, 1'b1, 1'b0, '0));
    plan.insert(plan.size(), reg_row(zps_pkg::CfgTargetCompact, 32'hffff_ffff));
    plan.insert(plan.size(), beat_row(AllOnes, '1, 1'b0, 1'b0, '0));
    plan.insert(plan.size(), beat_row(AllOnes, '1, 1'b1, 1'b0, '0));
    plan.insert(plan.size(), beat_row({4{64'haaaa_5555_aaaa_5555}}, 32'h5555_aaaa, 1'b1, 1'b0,
                                      '0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed plan; registers are only written with the pipeline empty.
    for (int r = 0; r < plan.size(); r++) begin
      if (plan[r].reg_write) begin
        if (r == 0 || !plan[r-1].reg_write) settle_pipeline();
        write_reg(plan[r].reg_idx, plan[r].reg_val);
        if (r + 1 == plan.size() || !plan[r+1].reg_write) cfg_if.valid <= 1'b0;
      end else begin
        offer_beat(plan[r].beat, plan[r].typed, plan[r].stats);
      end
    end

    // Random phases, each with its own register setting, zone length and idle pattern.
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle_pipeline();
      case (ph)
        0: begin
          tgt_word = zps_pkg::TargetReset;
          for (int i = 0; i < NumThr; i++) thr_word[i] = CfgValW'(zps_pkg::ThrReset[i]);
          zone_len_max = 12;
        end
        1: begin
          tgt_word = '0;
          thr_word = '{32'd0, 32'd256, 32'd257, 32'd511};
          zone_len_max = 4;
        end
        2: begin
          tgt_word = 32'h207f_ffff;
          thr_word = '{32'd1, 32'd8, 32'd16, 32'd24};
          zone_len_max = 2;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: tgt_word = $urandom();
            1: tgt_word = {8'($urandom_range(0, 36)), 1'($urandom_range(0, 1)), 23'($urandom())};
            2: tgt_word = {8'($urandom_range(0, 36)), 1'b0, 23'($urandom_range(0, 16'hffff))};
            default: tgt_word = {8'($urandom_range(28, 32)), 1'b0, 23'($urandom())};
          endcase
          for (int i = 0; i < NumThr; i++) begin
            case ($urandom_range(0, 4))
              0: thr_val = ThrW'($urandom_range(0, 511));
              1: thr_val = ThrW'($urandom_range(0, 64));
              2: thr_val = $urandom_range(0, 1) ? ThrW'(0) : ThrW'(256 + $urandom_range(0, 1));
              default: thr_val = ThrW'($urandom_range(16, 64));
            endcase
            thr_word[i] = {($urandom_range(0, 1) ? 23'($urandom()) : 23'd0), thr_val};
          end
          case ($urandom_range(0, 3))
            0:       zone_len_max = 1;
            1:       zone_len_max = 4;
            2:       zone_len_max = 12;
            default: zone_len_max = 48;
          endcase
        end
      endcase
      write_reg(zps_pkg::CfgTargetCompact, tgt_word);
      for (int i = 0; i < NumThr; i++) begin
        write_reg(CfgIdxW'(zps_pkg::CfgThreshold0) + CfgIdxW'(i), thr_word[i]);
      end
      cfg_if.valid <= 1'b0;

      send_burst = ($urandom_range(0, 3) == 0);
      take_burst = ($urandom_range(0, 3) == 0);
      // Short zones at full input rate while the result side holds off fill the block.
      if (ph == HoldPhase) begin
        send_burst   = 1'b1;
        take_burst   = 1'b0;
        res_hold_req = 1'b1;
      end

      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (zone_left == 0) zone_left = $urandom_range(1, zone_len_max);
        zone_left--;
        last = (zone_left == 0);
        if (ph == NumPhases - 1 && k == ItemsPerPhase - 1) last = 1'b1;
        v = draw_digest(expand_compact(target_cfg));
        n = ($urandom_range(0, 3) == 0) ? NonceW'($urandom_range(0, 15)) : NonceW'($urandom());
        prev_digest = v;
        offer_beat(pack_digest(v, n, last), 1'b0, '0);
      end
    end

    settle_pipeline();
    $display("summary: %0d digests, %0d zone results, %0d register writes, %0d phases",
             digests_seen, results_seen, reg_writes, NumPhases);
    $display("summary: %0d long result holds, input held back for %0d cycles, %0d mismatches",
             long_holds, in_stall_cyc, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
